### hdl/sfp_pkg.sv
// Shared constants and types for the sync frame pose parser.
package sfp_pkg;

    localparam logic [7:0] SYNC_FIRST     = 8'hFA;
    localparam logic [7:0] SYNC_SECOND    = 8'hFB;
    localparam logic [7:0] CMD_POSE_A     = 8'h32;
    localparam logic [7:0] CMD_POSE_B     = 8'h33;
    localparam logic [7:0] POSE_MIN_COUNT = 8'd7;
    localparam int unsigned NUM_WORDS     = 3;

    localparam int unsigned DEG_W = 25;

    typedef struct packed {
        logic [7:0]         command;
        logic [7:0]         frame_length;
        logic               position_updated;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        theta_raw;
        logic [DEG_W-1:0]   theta_deg_q12;
    } res_t;

endpackage

### hdl/sfp_in_if.sv
// Received byte channel.
interface sfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### hdl/sfp_out_if.sv
// Completed frame report channel.
interface sfp_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         command;
    logic [7:0]         frame_length;
    logic               position_updated;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        theta_raw;
    logic [24:0]        theta_deg_q12;

    modport source (output valid, output command, output frame_length,
                    output position_updated, output pos_x, output pos_y,
                    output theta_raw, output theta_deg_q12, input ready);
    modport sink   (input valid, input command, input frame_length,
                    input position_updated, input pos_x, input pos_y,
                    input theta_raw, input theta_deg_q12, output ready);
endinterface

### hdl/sfp_parser.sv
// Frame parsing state machine, payload staging and kept pose.
module sfp_parser
    import sfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] rx_byte,
    output logic       has_result,
    output res_t       res
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_COUNT,
        PH_DATA
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] staged_reg [NUM_WORDS];
    logic [15:0] staged_next [NUM_WORDS];
    logic [15:0] pose_reg [NUM_WORDS];
    logic [15:0] pose_next [NUM_WORDS];
    logic        last;
    logic        upd;
    logic [DEG_W-1:0] theta_ext;

    // last payload byte when the remaining count drops to zero
    assign last       = (left_reg <= 8'd1);
    assign has_result = (phase_reg == PH_DATA) && last;

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        staged_next = staged_reg;
        pose_next   = pose_reg;
        upd = 1'b0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == SYNC_FIRST)
                    phase_next = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                phase_next = (rx_byte == SYNC_SECOND) ? PH_COUNT : PH_HUNT;
            end
            PH_COUNT:
            begin
                count_next = rx_byte;
                left_next  = rx_byte;
                idx_next   = '0;
                cmd_next   = '0;
                for (int k = 0; k < NUM_WORDS; k++)
                    staged_next[k] = '0;
                phase_next = (rx_byte == 8'd0) ? PH_HUNT : PH_DATA;
            end
            PH_DATA:
            begin
                if (idx_reg == 8'd0)
                    cmd_next = rx_byte;
                // word k: low byte at index 2k+1, high byte at 2k+2
                for (int k = 0; k < NUM_WORDS; k++)
                begin
                    if (idx_reg == 8'(2 * k + 1))
                        staged_next[k][7:0] = rx_byte;
                    if (idx_reg == 8'(2 * k + 2))
                        staged_next[k][15:8] = rx_byte;
                end
                if (idx_reg != 8'hFF)
                    idx_next = idx_reg + 8'd1;
                if (left_reg != 8'd0)
                    left_next = left_reg - 8'd1;
                if (last)
                begin
                    phase_next = PH_HUNT;
                    upd = ((cmd_next == CMD_POSE_A) || (cmd_next == CMD_POSE_B))
                          && (count_reg >= POSE_MIN_COUNT);
                    if (upd)
                        pose_next = staged_next;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // degrees in Q.12: raw * 360 = raw * (256 + 64 + 32 + 8)
    assign theta_ext = DEG_W'(pose_next[2]);

    always_comb
    begin
        res.command          = cmd_next;
        res.frame_length     = count_reg;
        res.position_updated = upd;
        res.pos_x            = $signed(pose_next[0]);
        res.pos_y            = $signed(pose_next[1]);
        res.theta_raw        = pose_next[2];
        res.theta_deg_q12    = (theta_ext << 8) + (theta_ext << 6)
                             + (theta_ext << 5) + (theta_ext << 3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            left_reg  <= '0;
            idx_reg   <= '0;
            cmd_reg   <= '0;
            count_reg <= '0;
            for (int k = 0; k < NUM_WORDS; k++)
            begin
                staged_reg[k] <= '0;
                pose_reg[k]   <= '0;
            end
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            idx_reg    <= idx_next;
            cmd_reg    <= cmd_next;
            count_reg  <= count_next;
            staged_reg <= staged_next;
            pose_reg   <= pose_next;
        end
    end

    a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (left_reg != 8'd0))
        else $error("payload phase with no bytes left");

    a_empty_frame_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (phase_reg == PH_COUNT) && (rx_byte == 8'd0)) |=> (phase_reg == PH_HUNT))
        else $error("empty frame did not return to hunting");

endmodule

### hdl/sfp_out_stage.sv
// Result register in front of the report channel.
module sfp_out_stage
    import sfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  res_t      res,
    output logic      free,
    sfp_out_if.source out
);

    logic valid_reg, valid_next;
    res_t data_reg;

    assign free       = !valid_reg || out.ready;
    assign valid_next = load || (valid_reg && !out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign out.valid            = valid_reg;
    assign out.command          = data_reg.command;
    assign out.frame_length     = data_reg.frame_length;
    assign out.position_updated = data_reg.position_updated;
    assign out.pos_x            = data_reg.pos_x;
    assign out.pos_y            = data_reg.pos_y;
    assign out.theta_raw        = data_reg.theta_raw;
    assign out.theta_deg_q12    = data_reg.theta_deg_q12;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result loaded over an untaken request");

    a_update_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && data_reg.position_updated) |-> (data_reg.frame_length >= POSE_MIN_COUNT))
        else $error("pose update reported on a short frame");

    a_deg_matches_raw: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.theta_deg_q12 == DEG_W'(data_reg.theta_raw) * DEG_W'(360)))
        else $error("heading in degrees does not match raw heading");

endmodule

### hdl/sync_frame_pose_parser.sv
// Top level: input byte register, frame parser and result register.
//
//  channel  dir  payload                                         when
//  rx       in   rx_byte                                         valid & ready
//  res      out  command, frame_length, position_updated,        valid & ready
//                pos_x, pos_y, theta_raw, theta_deg_q12
//
// One byte is taken per cycle unless a held report stalls a frame's final byte;
// a byte is held in the input register, then the parser updates its state and,
// on the last payload byte, loads the result register that drives the report.
// Reset clears the parse state and the kept pose to zero.
// A held report stalls only a byte that ends a frame; other bytes keep flowing.
module sync_frame_pose_parser
    import sfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    sfp_in_if.sink   rx,
    sfp_out_if.source res
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       fire;
    logic       has_result;
    logic       out_free;
    res_t       result;

    // byte leaves the input register unless it ends a frame and the report is held
    assign fire     = in_valid_reg && (!has_result || out_free);
    assign rx.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            in_byte_reg <= rx.rx_byte;
    end

    sfp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .rx_byte    (in_byte_reg),
        .has_result (has_result),
        .res        (result)
    );

    sfp_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fire && has_result),
        .res   (result),
        .free  (out_free),
        .out   (res)
    );

    a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && has_result) |=> res.valid)
        else $error("finished frame gave no request");

endmodule

### bench/sync_frame_pose_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the sync frame pose parser: random byte streams, scored frame reports.
module sync_frame_pose_parser_tb;
    import sfp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1200;
    localparam int DEG_PER_TURN = 360;

    typedef enum logic [1:0] {PH_HUNT, PH_SYNC2, PH_COUNT, PH_DATA} parse_phase_t;

    logic clk;
    logic rst_n;

    sfp_in_if  rx_ch ();
    sfp_out_if res_ch ();

    sync_frame_pose_parser dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    // Bench-side parser state
    parse_phase_t phase;
    logic [7:0]   bytes_left;
    logic [7:0]   payload_idx;
    logic [7:0]   frame_cmd;
    logic [7:0]   frame_cnt;
    logic [15:0]  staged [3];
    logic [15:0]  kept [3];

    logic [7:0] bytes_to_send [$];
    res_t       frames_due [$];

    int errors;
    int bytes_sent;
    int frames_checked;
    int updates_due;
    int empty_frames;
    int cycle_count;
    int calm_cycles;
    int rx_gap;
    int res_stall;
    bit long_frame_done;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones; none during a calm stretch.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm_cycles != 0 || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Work out what one accepted byte does; queue a report on a frame's last byte.
    task automatic parse_byte(input logic [7:0] b);
        logic upd;
        res_t rep;
        case (phase)
            PH_HUNT:
            begin
                if (b == SYNC_FIRST)
                    phase = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                // the byte after a broken sync is not rechecked for the first sync
                phase = (b == SYNC_SECOND) ? PH_COUNT : PH_HUNT;
            end
            PH_COUNT:
            begin
                frame_cnt   = b;
                bytes_left  = b;
                payload_idx = 8'd0;
                frame_cmd   = 8'd0;
                staged      = '{default: 16'd0};
                if (b == 8'd0)
                begin
                    phase = PH_HUNT;
                    empty_frames++;
                end
                else
                begin
                    phase = PH_DATA;
                end
            end
            default:
            begin
                if (payload_idx == 8'd0)
                    frame_cmd = b;
                else if (payload_idx <= 8'd6)
                begin
                    if (payload_idx[0])
                        staged[(payload_idx - 8'd1) >> 1][7:0] = b;
                    else
                        staged[(payload_idx - 8'd1) >> 1][15:8] = b;
                end
                if (payload_idx != 8'hFF)
                    payload_idx = payload_idx + 8'd1;
                if (bytes_left != 8'd0)
                    bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0)
                begin
                    phase = PH_HUNT;
                    upd = (frame_cmd == CMD_POSE_A || frame_cmd == CMD_POSE_B)
                          && frame_cnt >= POSE_MIN_COUNT;
                    if (upd)
                    begin
                        kept = staged;
                        updates_due++;
                    end
                    rep.command          = frame_cmd;
                    rep.frame_length     = frame_cnt;
                    rep.position_updated = upd;
                    rep.pos_x            = kept[0];
                    rep.pos_y            = kept[1];
                    rep.theta_raw        = kept[2];
                    rep.theta_deg_q12    = DEG_W'(kept[2]) * DEG_W'(DEG_PER_TURN);
                    frames_due.push_back(rep);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic score_report();
        res_t want;
        if (frames_due.size() == 0)
        begin
            $display("%0t: report with none expected, expected nothing, got command %h",
                     $time, res_ch.command);
            errors++;
        end
        else
        begin
            want = frames_due.pop_front();
            check_field("command", want.command, res_ch.command);
            check_field("frame_length", want.frame_length, res_ch.frame_length);
            check_field("position_updated", want.position_updated, res_ch.position_updated);
            check_field("pos_x", want.pos_x, res_ch.pos_x);
            check_field("pos_y", want.pos_y, res_ch.pos_y);
            check_field("theta_raw", want.theta_raw, res_ch.theta_raw);
            check_field("theta_deg_q12", want.theta_deg_q12, res_ch.theta_deg_q12);
            frames_checked++;
        end
    endtask

    function automatic logic [7:0] payload_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'h00;
        if (r < 16)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Sync, count, then up to 'sent' payload bytes led by the command.
    task automatic push_frame(input logic [7:0] cmd, input logic [7:0] count, input int sent);
        int n;
        n = (sent < count) ? sent : count;
        bytes_to_send.push_back(SYNC_FIRST);
        bytes_to_send.push_back(SYNC_SECOND);
        bytes_to_send.push_back(count);
        for (int i = 0; i < n; i++)
            bytes_to_send.push_back(i == 0 ? cmd : payload_byte());
    endtask

    task automatic push_random_frame();
        int r;
        logic [7:0] cmd;
        logic [7:0] count;
        r = $urandom_range(0, 99);
        if (r < 10)
            count = 8'd0;
        else if (r < 50)
            count = 8'($urandom_range(7, 10));
        else if (r < 80)
            count = 8'($urandom_range(1, 6));
        else
            count = 8'($urandom_range(11, 30));
        if (!long_frame_done && bytes_to_send.size() > 600)
        begin
            count = 8'hFF;
            long_frame_done = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 22)
            cmd = CMD_POSE_A;
        else if (r < 44)
            cmd = CMD_POSE_B;
        else if (r < 50)
            cmd = (r < 47) ? SYNC_FIRST : SYNC_SECOND;
        else
            cmd = 8'($urandom);
        push_frame(cmd, count, 256);
    endtask

    // Byte source
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_ch.valid <= 1'b0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                parse_byte(rx_ch.rx_byte);
                bytes_sent++;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (rx_gap > 0)
                begin
                    rx_gap      <= rx_gap - 1;
                    rx_ch.valid <= 1'b0;
                end
                else if (bytes_to_send.size() != 0)
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= bytes_to_send.pop_front();
                    rx_gap        <= idle_length();
                end
                else
                begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Report sink with random back-pressure
    always @(posedge clk)
    begin
        int len;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
                score_report();
            len = ($urandom_range(0, 99) < 25) ? idle_length() : 0;
            if (res_stall > 0)
            begin
                res_stall    <= res_stall - 1;
                res_ch.ready <= 1'b0;
            end
            else if (len > 0)
            begin
                res_stall    <= len - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog and calm stretches
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (calm_cycles > 0)
            calm_cycles <= calm_cycles - 1;
        else if ($urandom_range(0, 499) == 0)
            calm_cycles <= $urandom_range(50, 300);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d reports outstanding",
                     cycle_count, frames_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int r;
        int stop_at;
        clk           = 1'b0;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'd0;
        res_ch.ready  = 1'b0;
        phase         = PH_HUNT;
        bytes_left    = 8'd0;
        payload_idx   = 8'd0;
        frame_cmd     = 8'd0;
        frame_cnt     = 8'd0;
        staged        = '{default: 16'd0};
        kept          = '{default: 16'd0};
        errors        = 0;
        bytes_sent    = 0;
        frames_checked = 0;
        updates_due   = 0;
        empty_frames  = 0;
        cycle_count   = 0;
        calm_cycles   = 0;
        rx_gap        = 0;
        res_stall     = 0;
        long_frame_done = 1'b0;

        // Directed: extreme pose words, broken syncs, empty, short pose and foreign frames
        bytes_to_send = {SYNC_FIRST, SYNC_SECOND, POSE_MIN_COUNT, CMD_POSE_A,
                         8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF,
                         SYNC_FIRST, 8'h00,
                         SYNC_FIRST, SYNC_FIRST, SYNC_SECOND,
                         SYNC_FIRST, SYNC_SECOND, 8'h00,
                         SYNC_FIRST, SYNC_SECOND, 8'h01, CMD_POSE_B,
                         SYNC_FIRST, SYNC_SECOND, 8'h01, 8'hFF};

        stop_at = bytes_to_send.size() + RANDOM_BYTES;
        while (bytes_to_send.size() < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                push_random_frame();
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 4))
                    bytes_to_send.push_back(8'($urandom));
            end
            else if (r < 90)
            begin
                bytes_to_send.push_back(SYNC_FIRST);
                bytes_to_send.push_back(($urandom_range(0, 2) == 0) ? SYNC_FIRST
                                        : (8'($urandom) | 8'h01) ^ 8'h00);
            end
            else
            begin
                // cut short: following bytes are taken as payload
                push_frame(CMD_POSE_A, 8'($urandom_range(2, 12)), $urandom_range(0, 4));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (bytes_to_send.size() != 0 || rx_ch.valid || frames_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Fed %0d bytes: frames, broken syncs, cut-short frames and noise.", bytes_sent);
        $display("Scored %0d reports (%0d pose updates), %0d empty frames skipped.",
                 frames_checked, updates_due, empty_frames);
        if (errors == 0 && frames_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
